// ----- rtl/cfrp_pkg.sv -----
// Shared types, codes and constants for the CAN frame record parser.
// Used by every module under rtl; no dependencies of its own.
`timescale 1ns / 1ps

package cfrp_pkg;

	localparam int HDR_BYTES  = 24;
	localparam int MAX_DATA   = 64;
	localparam int POS_W      = 7;
	localparam int OUT_DATA_W = 160;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_HEADER = 2'd1,
		ERR_TRUNC  = 2'd2
	} err_code_t;

	// One result item as it travels from the parser to the output stage
	typedef struct packed {
		res_kind_t   kind;
		logic [4:0]  flags;
		logic [28:0] ident;
		logic [63:0] stamp;
		logic [31:0] seq;
		logic [3:0]  dlc;
		logic [6:0]  len;
		logic [7:0]  pbyte;
		logic [5:0]  idx;
		logic        last;
		err_code_t   err;
	} res_t;

	// Queue status seen by the parser
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// CAN FD data length for a DLC
	function automatic logic [6:0] fd_len(input logic [3:0] dlc);
		logic [6:0] n;
		unique case (dlc)
			4'd9:    n = 7'd12;
			4'd10:   n = 7'd16;
			4'd11:   n = 7'd20;
			4'd12:   n = 7'd24;
			4'd13:   n = 7'd32;
			4'd14:   n = 7'd48;
			4'd15:   n = 7'd64;
			default: n = {3'd0, dlc};
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/can_frame_record_parser.sv -----
// Top level of the CAN frame record parser: front end, result queue and output stage.
// Depends on cfrp_pkg, cfrp_front, cfrp_queue and cfrp_back.
`timescale 1ns / 1ps

// Parses a little-endian byte stream of CAN frame records (24-byte header plus
// 0 to 64 data bytes), one byte per cycle with s_tlast marking the end of the
// available buffer. Each record gives one header item and one item per data
// byte, the last one with m_tlast set; a bad header or a buffer end inside a
// record gives one error item, and after a bad header bytes are dropped up to
// the buffer end. A byte is taken every cycle while the two-entry result queue
// has room; results pass through the queue write, then the output register.
// With results streaming the queue holds one item, so input stalls once the
// output is held and the second queue entry fills. cfg_data sets the
// transmit check and is always accepted.

module can_frame_record_parser import cfrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,   // tx_check
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // [7:0] data_byte
	input  logic                  s_tlast,    // buffer_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [4:0] flag_bits, [33:5] can_ident, [97:34] stamp_us, [129:98] seq_number,
	// [133:130] dlc_code, [140:134] payload_len, [148:141] payload_byte,
	// [154:149] byte_index, [156:155] error_code, [159:157] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,    // [1:0] res_kind
	output logic                  m_tlast     // record_last
);

	logic    tx_check_q;
	logic    push, pop;
	res_t    push_res, head;
	q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	// Hold the transmit check setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tx_check_q <= 1'b0;
		else if (cfg_valid)
			tx_check_q <= cfg_data;
	end

	cfrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tx_check (tx_check_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.push_res (push_res)
	);

	cfrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	cfrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/cfrp_front.sv -----
// Front end: accepts record bytes, captures header fields, validates the header
// and classifies each byte into a result item or none. Depends on cfrp_pkg.
`timescale 1ns / 1ps

module cfrp_front import cfrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tx_check,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // buffer_end
	input  q_stat_t    q_stat,
	output logic       push,
	output res_t       push_res
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic             skip_q, skip_d;
	logic             zv_q, zv_d;
	logic [15:0]      flags_q;
	logic [31:0]      ident_q;
	logic [63:0]      stamp_q;
	logic [31:0]      seq_q;
	logic [7:0]       dlc_q;
	logic [7:0]       len_q;

	logic             acc;
	logic [7:0]       b;
	logic             at_end;
	logic             zv_now;
	logic             ext, rtr, fd, ident_ok, hdr_ok;
	logic [POS_W-1:0] idx_w;
	logic             data_last;

	assign s_tready = !q_stat.full;
	assign acc      = s_tvalid && s_tready;
	assign b        = s_tdata;
	assign at_end   = s_tlast;

	// Header check on the final header byte
	assign zv_now   = zv_q || (b != 8'd0);
	assign ext      = flags_q[0];
	assign rtr      = flags_q[1];
	assign fd       = flags_q[2];
	assign ident_ok = ext ? (ident_q[31:29] == 3'd0) : (ident_q[31:11] == 21'd0);
	assign hdr_ok   = !zv_now && (flags_q[15:5] == 11'd0) && ident_ok
		&& (dlc_q[7:4] == 4'd0) && (len_q <= 8'(MAX_DATA))
		&& (fd || ((dlc_q <= 8'd8) && (flags_q[4:3] == 2'd0)))
		&& !(fd && rtr)
		&& (len_q == (rtr ? 8'd0 : {1'b0, fd_len(dlc_q[3:0])}))
		&& !(tx_check && (flags_q[4] || (stamp_q != 64'd0) || (seq_q != 32'd0)));

	// Data position and end of frame
	assign idx_w     = pos_q - POS_W'(HDR_BYTES);
	assign data_last = ({1'b0, idx_w} + 8'd1) >= len_q;

	// Classify the byte and advance the record position
	always_comb begin
		pos_d    = pos_q;
		skip_d   = skip_q;
		zv_d     = zv_q;
		push     = 1'b0;
		push_res = '0;
		push_res.flags = flags_q[4:0];
		push_res.ident = ident_q[28:0];
		push_res.stamp = stamp_q;
		push_res.seq   = seq_q;
		push_res.dlc   = dlc_q[3:0];
		push_res.len   = len_q[6:0];
		push_res.pbyte = b;
		push_res.idx   = idx_w[5:0];
		push_res.kind  = KIND_ERROR;
		push_res.err   = ERR_NONE;
		push_res.last  = 1'b1;
		if (acc) begin
			if (skip_q) begin
				if (at_end) begin
					skip_d = 1'b0;
					pos_d  = '0;
				end
			end else if (pos_q < POS_W'(HDR_BYTES)) begin
				if (pos_q == '0)
					zv_d = (b != 8'd0);
				else if (pos_q == POS_W'(1) || pos_q >= POS_W'(22))
					zv_d = zv_now;
				if (pos_q < POS_W'(HDR_BYTES - 1)) begin
					if (at_end) begin
						push         = 1'b1;
						push_res.err = ERR_TRUNC;
						pos_d        = '0;
					end else begin
						pos_d = pos_q + POS_W'(1);
					end
				end else if (!hdr_ok) begin
					push         = 1'b1;
					push_res.err = ERR_HEADER;
					pos_d        = '0;
					skip_d       = !at_end;
				end else if (at_end && len_q != 8'd0) begin
					push         = 1'b1;
					push_res.err = ERR_TRUNC;
					pos_d        = '0;
				end else begin
					push          = 1'b1;
					push_res.kind = KIND_HEADER;
					push_res.last = (len_q == 8'd0);
					pos_d         = (len_q == 8'd0) ? '0 : POS_W'(HDR_BYTES);
				end
			end else if (at_end && !data_last) begin
				push         = 1'b1;
				push_res.err = ERR_TRUNC;
				pos_d        = '0;
			end else begin
				push          = 1'b1;
				push_res.kind = KIND_DATA;
				push_res.last = data_last;
				pos_d         = data_last ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			skip_q <= 1'b0;
			zv_q   <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			skip_q <= skip_d;
			zv_q   <= zv_d;
		end
	end

	// Capture header fields, little-endian
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			ident_q <= '0;
			stamp_q <= '0;
			seq_q   <= '0;
			dlc_q   <= '0;
			len_q   <= '0;
		end else if (acc && !skip_q && pos_q < POS_W'(HDR_BYTES)) begin
			if (pos_q >= POS_W'(2) && pos_q < POS_W'(4))
				flags_q[8*pos_q[0] +: 8] <= b;
			else if (pos_q >= POS_W'(4) && pos_q < POS_W'(8))
				ident_q[8*pos_q[1:0] +: 8] <= b;
			else if (pos_q >= POS_W'(8) && pos_q < POS_W'(16))
				stamp_q[8*pos_q[2:0] +: 8] <= b;
			else if (pos_q >= POS_W'(16) && pos_q < POS_W'(20))
				seq_q[8*pos_q[1:0] +: 8] <= b;
			else if (pos_q == POS_W'(20))
				dlc_q <= b;
			else if (pos_q == POS_W'(21))
				len_q <= b;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(HDR_BYTES + MAX_DATA))
		else $error("record position out of range");

	a_skip_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> pos_q == '0)
		else $error("discarding while inside a record");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_res.kind == KIND_ERROR) |-> (push_res.last && push_res.err != ERR_NONE))
		else $error("error item not marked last");

endmodule

// ----- rtl/cfrp_queue.sv -----
// Two-entry queue of result items between parser and output stage.
// Depends on cfrp_pkg.
`timescale 1ns / 1ps

module cfrp_queue import cfrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  res_t    push_res,
	input  logic    pop,
	output res_t    head,
	output q_stat_t stat
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign head       = mem_q[rd_ptr_q];

	// Write entry
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_res;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

// ----- rtl/cfrp_back.sv -----
// Back end: takes queued result items, clears the fields that do not apply
// to the item kind, and holds the item in the output register. Depends on cfrp_pkg.
`timescale 1ns / 1ps

module cfrp_back import cfrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_stat_t               q_stat,
	input  res_t                  head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] tdata_q, tdata_d;
	logic [1:0]            tuser_q;
	logic                  tlast_q;
	res_t                  f;

	assign pop = !q_stat.empty && (!valid_q || m_tready);

	// Keep only the fields that belong to the item kind
	always_comb begin
		f = '0;
		f.kind = head.kind;
		f.last = head.last;
		unique case (head.kind)
			KIND_HEADER: begin
				f.flags = head.flags;
				f.ident = head.ident;
				f.stamp = head.stamp;
				f.seq   = head.seq;
				f.dlc   = head.dlc;
				f.len   = head.len;
			end
			KIND_DATA: begin
				f.pbyte = head.pbyte;
				f.idx   = head.idx;
			end
			default: begin
				f.err  = head.err;
				f.last = 1'b1;
			end
		endcase
		tdata_d = {3'd0, f.err, f.idx, f.pbyte, f.len, f.dlc, f.seq, f.stamp, f.ident,
			f.flags};
	end

	// Load the output register when it is free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= tdata_d;
			tuser_q <= f.kind;
			tlast_q <= f.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

// ----- tb/sv/can_frame_record_parser_tb.sv -----
// Self-checking testbench for can_frame_record_parser: streams CAN frame records
// byte by byte and checks every result item against an in-bench parser model.
// Depends on cfrp_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module can_frame_record_parser_tb;
	import cfrp_pkg::*;

	localparam int AT_END       = -1;     // buffer end on the final byte of the record
	localparam int NO_END       = -2;     // record runs on into the next one
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_BYTES  = 30;

	localparam logic [6:0] DLC_LEN [16] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
		7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64};

	// One directed record: header fields, where the buffer ends, and the error it must give
	typedef struct packed {
		logic        tx;
		logic [15:0] chan;
		logic [15:0] flags;
		logic [31:0] ident;
		logic [63:0] stamp;
		logic [31:0] seq;
		logic [7:0]  dlc;
		logic [7:0]  len;
		logic [15:0] rsv;
		int          end_at;
		err_code_t   typed_err;
	} record_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	// Parser model state
	logic        tx_mode = 1'b0;
	int          pos_q = 0;
	logic [15:0] flags_q = '0;
	logic [31:0] ident_q = '0;
	logic [63:0] stamp_q = '0;
	logic [31:0] seq_q = '0;
	logic [7:0]  dlc_q = '0;
	logic [7:0]  len_q = '0;
	logic        zero_bad = 1'b0;
	logic        skipping = 1'b0;

	res_t expected_q [$];
	int   fail_count = 0;
	int   parsed_count = 0;
	int   cycle_count = 0;
	int   tx_burst = 0;
	int   rx_burst = 0;
	logic hold_request = 1'b0;

	record_row_t rows [24] = '{
		'{1'b0, 16'h0, 16'h0000, 32'h7ff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 8'd8, 8'd8,
			16'h0, AT_END, ERR_NONE},
		'{1'b0, 16'h0, 16'h001d, 32'h1fff_ffff, 64'h0, 32'h0, 8'd15, 8'd64, 16'h0, NO_END,
			ERR_NONE},
		'{1'b0, 16'h0, 16'h0002, 32'h0, 64'h0, 32'h0, 8'd8, 8'd0, 16'h0, AT_END, ERR_NONE},
		'{1'b0, 16'h0100, 16'h0, 32'h0, 64'h0, 32'h0, 8'd0, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0, 32'h1, 64'h0, 32'h0, 8'd8, 8'd8, 16'h8000, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0020, 32'h0, 64'h0, 32'h0, 8'd1, 8'd1, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h8000, 32'h0, 64'h0, 32'h0, 8'd0, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0000, 32'h800, 64'h0, 32'h0, 8'd0, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0001, 32'h2000_0000, 64'h0, 32'h0, 8'd0, 8'd0, 16'h0, AT_END,
			ERR_HEADER},
		'{1'b0, 16'h0, 16'h0004, 32'h0, 64'h0, 32'h0, 8'h10, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0004, 32'h0, 64'h0, 32'h0, 8'd15, 8'd65, 16'h0, 23, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0000, 32'h0, 64'h0, 32'h0, 8'd9, 8'd12, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0008, 32'h0, 64'h0, 32'h0, 8'd1, 8'd1, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0006, 32'h0, 64'h0, 32'h0, 8'd0, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0002, 32'h0, 64'h0, 32'h0, 8'd1, 8'd1, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0004, 32'h0, 64'h0, 32'h0, 8'd9, 8'd11, 16'h0, AT_END, ERR_HEADER},
		'{1'b0, 16'h0, 16'h0000, 32'h123, 64'h0, 32'h0, 8'd8, 8'd8, 16'h0, 10, ERR_TRUNC},
		'{1'b0, 16'h0, 16'h0000, 32'h123, 64'h0, 32'h0, 8'd4, 8'd4, 16'h0, 23, ERR_TRUNC},
		'{1'b0, 16'h0, 16'h0000, 32'h123, 64'h0, 32'h0, 8'd8, 8'd8, 16'h0, 27, ERR_TRUNC},
		'{1'b0, 16'h0, 16'h0040, 32'h0, 64'h0, 32'h0, 8'd8, 8'd8, 16'h0, 23, ERR_HEADER},
		'{1'b1, 16'h0, 16'h000c, 32'h0, 64'h0, 32'h0, 8'd9, 8'd12, 16'h0, AT_END, ERR_NONE},
		'{1'b1, 16'h0, 16'h0014, 32'h0, 64'h0, 32'h0, 8'd1, 8'd1, 16'h0, AT_END, ERR_HEADER},
		'{1'b1, 16'h0, 16'h0000, 32'h0, 64'h1, 32'h0, 8'd0, 8'd0, 16'h0, AT_END, ERR_HEADER},
		'{1'b1, 16'h0, 16'h0000, 32'h0, 64'h0, 32'h8000_0000, 8'd0, 8'd0, 16'h0, AT_END,
			ERR_HEADER}
	};

	can_frame_record_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Draw a random wait, with occasional bursts of back-to-back items
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function void error_item(output res_t r, input err_code_t code, input logic at_end);
		r = '0;
		r.kind = KIND_ERROR;
		r.last = 1'b1;
		r.err = code;
		pos_q = 0;
		skipping = !at_end;
	endfunction

	function logic header_valid();
		logic ext, rtr, fd;
		ext = flags_q[0];
		rtr = flags_q[1];
		fd = flags_q[2];
		if (zero_bad || flags_q[15:5] != 0) return 1'b0;
		if (ident_q > (ext ? 32'h1fff_ffff : 32'h7ff)) return 1'b0;
		if (dlc_q > 8'd15 || len_q > 8'd64) return 1'b0;
		if (!fd && (dlc_q > 8'd8 || flags_q[4:3] != 0)) return 1'b0;
		if (fd && rtr) return 1'b0;
		if (len_q != (rtr ? 8'd0 : {1'b0, DLC_LEN[dlc_q[3:0]]})) return 1'b0;
		if (tx_mode && (flags_q[4] || stamp_q != 0 || seq_q != 0)) return 1'b0;
		return 1'b1;
	endfunction

	// Advance the parser model by one byte; return 1 when it gives a result
	function logic parse_byte(input logic [7:0] b, input logic at_end, output res_t r);
		int   p;
		int   idx;
		logic last_one;
		r = '0;
		p = pos_q;
		if (skipping) begin
			if (at_end) begin
				skipping = 1'b0;
				pos_q = 0;
			end
			return 1'b0;
		end
		parsed_count++;
		if (p < HDR_BYTES) begin
			// capture header fields, little-endian
			if (p == 0) zero_bad = (b != 0);
			else if (p == 1 || p >= 22) zero_bad = zero_bad || (b != 0);
			else if (p < 4) flags_q[(p - 2) * 8 +: 8] = b;
			else if (p < 8) ident_q[(p - 4) * 8 +: 8] = b;
			else if (p < 16) stamp_q[(p - 8) * 8 +: 8] = b;
			else if (p < 20) seq_q[(p - 16) * 8 +: 8] = b;
			else if (p == 20) dlc_q = b;
			else len_q = b;

			if (p < HDR_BYTES - 1) begin
				if (at_end) begin
					error_item(r, ERR_TRUNC, 1'b1);
					return 1'b1;
				end
				pos_q = p + 1;
				return 1'b0;
			end
			if (!header_valid()) begin
				error_item(r, ERR_HEADER, at_end);
				return 1'b1;
			end
			if (at_end && len_q != 0) begin
				error_item(r, ERR_TRUNC, 1'b1);
				return 1'b1;
			end
			r.kind = KIND_HEADER;
			r.flags = flags_q[4:0];
			r.ident = ident_q[28:0];
			r.stamp = stamp_q;
			r.seq = seq_q;
			r.dlc = dlc_q[3:0];
			r.len = len_q[6:0];
			r.last = (len_q == 0);
			pos_q = (len_q == 0) ? 0 : HDR_BYTES;
			return 1'b1;
		end
		// payload byte
		idx = p - HDR_BYTES;
		last_one = (idx + 1 >= len_q);
		if (at_end && !last_one) begin
			error_item(r, ERR_TRUNC, 1'b1);
			return 1'b1;
		end
		r.kind = KIND_DATA;
		r.pbyte = b;
		r.idx = idx[5:0];
		r.last = last_one;
		pos_q = last_one ? 0 : ((p + 1) & 127);
		return 1'b1;
	endfunction

	// Offer one byte, wait for it to be taken, then record what it must produce
	task automatic send_byte(input logic [7:0] b, input logic at_end, input err_code_t typed);
		int   gap;
		res_t r;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= at_end;
		do @(posedge clk); while (!s_tready);
		if (parse_byte(b, at_end, r)) begin
			// a typed-in error replaces the model's error item or the one at the buffer end
			if (typed != ERR_NONE && (r.kind == KIND_ERROR || at_end)) begin
				r = '0;
				r.kind = KIND_ERROR;
				r.last = 1'b1;
				r.err = typed;
			end
			expected_q.push_back(r);
		end
	endtask

	task automatic send_record(input logic [15:0] chan, input logic [15:0] flags,
		input logic [31:0] ident, input logic [63:0] stamp, input logic [31:0] seq,
		input logic [7:0] dlc, input logic [7:0] len, input logic [15:0] rsv,
		input int end_at, input err_code_t typed);
		logic [191:0] hdr;
		logic [7:0]   b;
		logic         e;
		int           total;
		hdr = {rsv, len, dlc, seq, stamp, ident, flags, chan};
		total = HDR_BYTES + len;
		for (int i = 0; i < total; i++) begin
			b = (i < HDR_BYTES) ? hdr[i * 8 +: 8] : 8'($urandom);
			e = (end_at == i) || (end_at == AT_END && i == total - 1);
			send_byte(b, e, typed);
			if (end_at == i) break;
		end
	endtask

	// Mostly well-formed records with random content; some broken or cut short
	task automatic send_random_record();
		logic [15:0] fl, ch, rs;
		logic [31:0] id, sq;
		logic [63:0] st;
		logic [7:0]  d, l;
		int          end_at;
		fl = {15'd0, 1'($urandom)};
		ch = '0;
		rs = '0;
		case ($urandom_range(0, 3))
			0, 1: begin
				d = 8'($urandom_range(0, 8));
				l = d;
			end
			2: begin
				fl[1] = 1'b1;
				d = 8'($urandom_range(0, 8));
				l = 8'd0;
			end
			default: begin
				fl[2] = 1'b1;
				fl[3] = 1'($urandom);
				fl[4] = tx_mode ? 1'b0 : 1'($urandom);
				d = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(9, 15))
					: 8'($urandom_range(0, 10));
				l = {1'b0, DLC_LEN[d[3:0]]};
			end
		endcase
		id = fl[0] ? ($urandom & 32'h1fff_ffff) : $urandom_range(0, 32'h7ff);
		st = tx_mode ? 64'd0 : {$urandom, $urandom};
		sq = tx_mode ? 32'd0 : $urandom;
		// break the header now and then
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 7))
				0: ch = 16'd1 << $urandom_range(0, 15);
				1: rs = 16'd1 << $urandom_range(0, 15);
				2: fl = fl | (16'd1 << $urandom_range(3, 15));
				3: id = id | (32'd1 << $urandom_range(11, 31));
				4: l = l ^ (8'd1 << $urandom_range(0, 7));
				5: d = 8'($urandom_range(0, 255));
				6: st = {$urandom, $urandom};
				default: sq = $urandom;
			endcase
		end
		case ($urandom_range(0, 7))
			0, 1, 2: end_at = NO_END;
			3: end_at = $urandom_range(0, HDR_BYTES - 1 + l);
			default: end_at = AT_END;
		endcase
		send_record(ch, fl, id, st, sq, d, l, rs, end_at, ERR_NONE);
	endtask

	// Drop valid and wait until every expected item has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tx_check(input logic v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tx_mode = v;
		cfg_valid <= 1'b0;
	endtask

	function void check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Output side: stall at random, hold off once for a long stretch, check each item
	initial begin
		int   stall;
		res_t exp_r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = draw_wait(rx_burst);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_q.size() == 0) begin
				$error("result item with no expectation: res_kind %0d", m_tuser);
				fail_count++;
			end else begin
				exp_r = expected_q.pop_front();
				check_field("res_kind", exp_r.kind, m_tuser);
				check_field("flag_bits", exp_r.flags, m_tdata[4:0]);
				check_field("can_ident", exp_r.ident, m_tdata[33:5]);
				check_field("stamp_us", exp_r.stamp, m_tdata[97:34]);
				check_field("seq_number", exp_r.seq, m_tdata[129:98]);
				check_field("dlc_code", exp_r.dlc, m_tdata[133:130]);
				check_field("payload_len", exp_r.len, m_tdata[140:134]);
				check_field("payload_byte", exp_r.pbyte, m_tdata[148:141]);
				check_field("byte_index", exp_r.idx, m_tdata[154:149]);
				check_field("error_code", exp_r.err, m_tdata[156:155]);
				check_field("tdata_pad", 64'd0, m_tdata[159:157]);
				check_field("record_last", exp_r.last, m_tlast);
			end
		end
	end

	// Input side: directed records, then random phases with the transmit check toggled
	initial begin
		int nbytes;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_tx_check(1'b0);

		// hold the output off while the first records stream in
		hold_request = 1'b1;
		for (int i = 0; i < $size(rows); i++) begin
			if (rows[i].tx != tx_mode) write_tx_check(rows[i].tx);
			send_record(rows[i].chan, rows[i].flags, rows[i].ident, rows[i].stamp,
				rows[i].seq, rows[i].dlc, rows[i].len, rows[i].rsv, rows[i].end_at,
				rows[i].typed_err);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0, 3: write_tx_check(1'b0);
				1: write_tx_check(1'b1);
				default: write_tx_check(1'($urandom));
			endcase
			parsed_count = 0;
			while (parsed_count < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise burst, closed by a buffer end
					nbytes = $urandom_range(1, 30);
					for (int k = 0; k < nbytes; k++)
						send_byte(8'($urandom), k == nbytes - 1, ERR_NONE);
				end else begin
					send_random_record();
				end
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
